FILE: hdl/dgm_pkg.sv
// ----------------------------------------------------------------------------
// dgm_pkg
// Shared types and constants of the dynamic time warping gesture matcher.
// ----------------------------------------------------------------------------
package dgm_pkg;

  // field widths
  localparam int SW     = 13;  // one axis of a sample
  localparam int DW     = 14;  // difference of two axis values
  localparam int SQW    = 26;  // square of a difference
  localparam int LW     = 28;  // local cost, sum of up to three squares
  localparam int COST_W = 36;  // cumulative cost
  localparam int CNT_W  = 4;   // sample count and window length

  // request opcodes
  localparam logic OP_REF_WRITE = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_W        = 1;
  localparam logic CFG_THRESHOLD    = 1'b0;
  localparam logic CFG_WINDOW_LEN   = 1'b1;

  localparam logic [COST_W-1:0] THRESHOLD_RST  = 36'd500000;
  localparam logic [CNT_W-1:0]  WINDOW_LEN_RST = 4'd14;
  localparam logic [COST_W-1:0] COST_MAX       = {COST_W{1'b1}};

  // flags that travel with a column through the sweep pipeline
  typedef struct packed {
    logic vld;
    logic first_row;
    logic first_col;
    logic last_col;
  } sweep_ctl_t;

endpackage

FILE: hdl/dgm_local_cost.sv
// ----------------------------------------------------------------------------
// dgm_local_cost
// Reference gesture memory and the per-axis squared differences of a cell.
// ----------------------------------------------------------------------------
module dgm_local_cost import dgm_pkg::*; #(
  parameter int WINDOW = 14,
  parameter int AXES   = 3,
  localparam int RW    = $clog2(WINDOW)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [RW-1:0]             wr_addr,
  input  logic [AXES-1:0][SW-1:0]   wr_row,
  input  logic [RW-1:0]             rd_addr,
  input  logic [AXES-1:0][SW-1:0]   sample,
  output logic [AXES-1:0][SQW-1:0]  sq
);

  logic [AXES-1:0][SW-1:0]  ref_mem [WINDOW];
  logic [AXES-1:0][SW-1:0]  ref_q_r;
  logic [AXES-1:0][SQW-1:0] sq_r;
  logic [AXES-1:0][SQW-1:0] sq_nxt;
  logic signed [DW-1:0]     diff [AXES];
  logic signed [2*DW-1:0]   prod [AXES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_mem[wr_addr] <= wr_row;
    end
    ref_q_r <= ref_mem[rd_addr];
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      diff[k]   = $signed({sample[k][SW-1], sample[k]}) -
                  $signed({ref_q_r[k][SW-1], ref_q_r[k]});
      prod[k]   = diff[k] * diff[k];
      sq_nxt[k] = prod[k][SQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

FILE: hdl/dgm_cost_row.sv
// ----------------------------------------------------------------------------
// dgm_cost_row
// Cumulative cost row memory and the warping recurrence, one cell a cycle.
// ----------------------------------------------------------------------------
module dgm_cost_row import dgm_pkg::*; #(
  parameter int WINDOW = 14,
  parameter int AXES   = 3,
  localparam int RW    = $clog2(WINDOW)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [RW-1:0]             rd_addr,
  input  sweep_ctl_t                ctl1,
  input  sweep_ctl_t                ctl2,
  input  logic [RW-1:0]             wr_addr,
  input  logic [AXES-1:0][SQW-1:0]  sq,
  output logic [COST_W-1:0]         new_cell
);

  logic [COST_W-1:0] cost_mem [WINDOW];
  logic [COST_W-1:0] cost_q_r;
  logic [COST_W-1:0] diag_hold_r;
  logic [COST_W-1:0] diag_hold_nxt;
  logic [COST_W-1:0] left_hold_r;
  logic [COST_W-1:0] left_hold_nxt;
  logic [COST_W-1:0] up_r;
  logic [COST_W-1:0] up_nxt;
  logic [COST_W-1:0] min_ud_r;
  logic [COST_W-1:0] min_ud_nxt;
  logic [LW-1:0]     local_cost;
  logic [COST_W-1:0] best;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cell_cost;

  // read of column c and write of column c-2 never meet on the same entry
  always_ff @(posedge clk) begin
    if (ctl2.vld) begin
      cost_mem[wr_addr] <= cell_cost;
    end
    cost_q_r <= cost_mem[rd_addr];
  end

  // first stage: up neighbour and min of up and diagonal
  always_comb begin
    up_nxt        = up_r;
    min_ud_nxt    = min_ud_r;
    diag_hold_nxt = diag_hold_r;
    if (ctl1.vld) begin
      up_nxt        = cost_q_r;
      min_ud_nxt    = (cost_q_r < diag_hold_r) ? cost_q_r : diag_hold_r;
      diag_hold_nxt = cost_q_r;
    end
  end

  // second stage: local cost plus best neighbour, saturating
  always_comb begin
    local_cost = '0;
    for (int k = 0; k < AXES; k++) begin
      local_cost = local_cost + LW'(sq[k]);
    end
    if (ctl2.first_row) begin
      best = ctl2.first_col ? '0 : left_hold_r;
    end else if (ctl2.first_col) begin
      best = up_r;
    end else begin
      best = (left_hold_r < min_ud_r) ? left_hold_r : min_ud_r;
    end
    sum  = {1'b0, best} + (COST_W+1)'(local_cost);
    cell_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    left_hold_nxt = ctl2.vld ? cell_cost : left_hold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_hold_r <= '0;
      left_hold_r <= '0;
    end else begin
      diag_hold_r <= diag_hold_nxt;
      left_hold_r <= left_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    up_r     <= up_nxt;
    min_ud_r <= min_ud_nxt;
  end

  assign new_cell = cell_cost;

endmodule

FILE: hdl/dtw_gesture_match.sv
// ----------------------------------------------------------------------------
// dtw_gesture_match
// Dynamic time warping match of 3-axis accelerometer windows to a reference.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): in_op selects a reference row write
// (row in_ref_index gets the sample) or a candidate sample. Result channel
// (out_valid / out_stall) carries the warping distance and the match flag,
// one result after every len candidate samples (len = clamped window length).
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 is the
// match threshold, index 1 the window length; write only while idle.
// A reference write does not make the block busy. A candidate sample sweeps
// the cost row at one cell a cycle through the reference and cost-row
// memories; the result of the last sample of a window is registered from
// the last cell of its sweep.
// The request after a sample is taken once the sweep has finished.
// Reset clears the sample count, the handshake state and the registers to
// threshold 500000 and length 14; the memories are not cleared, every used
// reference row has to be written first.
// A stalled result is held; further requests are still taken, except a
// sample that would end a window, which waits until the result has gone.
// ----------------------------------------------------------------------------
module dtw_gesture_match import dgm_pkg::*; #(
  parameter int WINDOW = 14,
  parameter int AXES   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [3:0]            in_ref_index,
  input  logic signed [SW-1:0]  in_sample_x,
  input  logic signed [SW-1:0]  in_sample_y,
  input  logic signed [SW-1:0]  in_sample_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COST_W-1:0]     out_distance,
  output logic                  out_is_match,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COST_W-1:0]     cfg_data
);

  localparam int RW = $clog2(WINDOW);
  localparam int CW = (RW > CNT_W) ? RW : CNT_W;

  logic [COST_W-1:0]        match_threshold_r;
  logic [CNT_W-1:0]         window_length_r;
  logic [CNT_W-1:0]         len;
  logic [CNT_W-1:0]         len_m1;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     ends_now;
  logic                     accept;
  logic                     start;
  logic                     ref_wr_en;
  logic [SW-1:0]            in_axes [3];
  logic [AXES-1:0][SW-1:0]  in_row;

  logic                     busy_r, busy_nxt;
  logic                     issue_vld_r, issue_vld_nxt;
  logic [RW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            col1_r, col2_r;
  logic                     first_row_r, first_row_nxt;
  logic                     ends_r, ends_nxt;
  logic [CNT_W-1:0]         sample_count_r, sample_count_nxt;
  logic [AXES-1:0][SW-1:0]  sample_r, sample_nxt;
  sweep_ctl_t               ctl0, ctl1_r, ctl2_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]        out_distance_r, out_distance_nxt;
  logic [AXES-1:0][SQW-1:0] sq;
  logic [COST_W-1:0]        new_cell;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_threshold_r <= THRESHOLD_RST;
      window_length_r   <= WINDOW_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD:  match_threshold_r <= cfg_data;
        CFG_WINDOW_LEN: window_length_r   <= cfg_data[CNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // effective window length, clamped to 1..WINDOW
  always_comb begin
    if (window_length_r == '0) begin
      len = CNT_W'(1);
    end else if (int'(window_length_r) > WINDOW) begin
      len = CNT_W'(WINDOW);
    end else begin
      len = window_length_r;
    end
    len_m1   = len - CNT_W'(1);
    cnt_inc  = sample_count_r + CNT_W'(1);
    ends_now = (cnt_inc >= len) || (cnt_inc == '0);
  end

  assign in_stall  = busy_r ||
                     ((in_op == OP_SAMPLE) && ends_now && out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign start     = accept && (in_op == OP_SAMPLE);
  assign ref_wr_en = accept && (in_op == OP_REF_WRITE) && (int'(in_ref_index) < WINDOW);

  always_comb begin
    in_axes[0] = in_sample_x;
    in_axes[1] = in_sample_y;
    in_axes[2] = in_sample_z;
    for (int k = 0; k < AXES; k++) begin
      in_row[k] = in_axes[k];
    end
  end

  assign ctl0.vld       = issue_vld_r;
  assign ctl0.first_row = first_row_r;
  assign ctl0.first_col = (col_r == '0);
  assign ctl0.last_col  = (CW'(col_r) == CW'(len_m1));

  // sweep sequencer
  always_comb begin
    busy_nxt         = busy_r;
    issue_vld_nxt    = issue_vld_r;
    col_nxt          = col_r;
    first_row_nxt    = first_row_r;
    ends_nxt         = ends_r;
    sample_count_nxt = sample_count_r;
    sample_nxt       = sample_r;
    out_valid_nxt    = out_valid_r;
    out_distance_nxt = out_distance_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (start) begin
      busy_nxt         = 1'b1;
      issue_vld_nxt    = 1'b1;
      col_nxt          = '0;
      first_row_nxt    = (sample_count_r == '0);
      ends_nxt         = ends_now;
      sample_count_nxt = ends_now ? '0 : cnt_inc;
      sample_nxt       = in_row;
    end else if (issue_vld_r) begin
      if (ctl0.last_col) begin
        issue_vld_nxt = 1'b0;
      end else begin
        col_nxt = col_r + RW'(1);
      end
    end

    if (ctl2_r.vld && ctl2_r.last_col) begin
      busy_nxt = 1'b0;
      if (ends_r) begin
        out_valid_nxt    = 1'b1;
        out_distance_nxt = new_cell;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      issue_vld_r    <= 1'b0;
      sample_count_r <= '0;
      ctl1_r         <= '0;
      ctl2_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      issue_vld_r    <= issue_vld_nxt;
      sample_count_r <= sample_count_nxt;
      ctl1_r         <= ctl0;
      ctl2_r         <= ctl1_r;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r          <= col_nxt;
    col1_r         <= col_r;
    col2_r         <= col1_r;
    first_row_r    <= first_row_nxt;
    ends_r         <= ends_nxt;
    sample_r       <= sample_nxt;
    out_distance_r <= out_distance_nxt;
  end

  dgm_local_cost #(
    .WINDOW (WINDOW),
    .AXES   (AXES)
  ) u_local_cost (
    .clk     (clk),
    .wr_en   (ref_wr_en),
    .wr_addr (RW'(in_ref_index)),
    .wr_row  (in_row),
    .rd_addr (col_r),
    .sample  (sample_r),
    .sq      (sq)
  );

  dgm_cost_row #(
    .WINDOW (WINDOW),
    .AXES   (AXES)
  ) u_cost_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (col_r),
    .ctl1     (ctl1_r),
    .ctl2     (ctl2_r),
    .wr_addr  (col2_r),
    .sq       (sq),
    .new_cell (new_cell)
  );

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_is_match = (out_distance_r < match_threshold_r);

endmodule

FILE: hdl/dgm_checker.sv
// ----------------------------------------------------------------------------
// dgm_checker
// Port-level checks of the gesture matcher, bound to the top level.
// ----------------------------------------------------------------------------
module dgm_checker import dgm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COST_W-1:0] out_distance
);

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance))
    else $error("held result changed");

  // a sample keeps the block busy for its sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_SAMPLE) |=> in_stall)
    else $error("request taken during a sweep");

  // a result only comes out at the end of a sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sweep");

  // a reference write makes no result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_REF_WRITE) |=> !$rose(out_valid))
    else $error("result after a reference write");

  // nothing pending right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind dtw_gesture_match dgm_checker u_dgm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_distance (out_distance)
);

FILE: tb/sv/dtw_gesture_match_check.sv
// ----------------------------------------------------------------------------
// dtw_gesture_match_check
// Watches the request, result and configuration channels of the gesture
// matcher, keeps its own copy of the reference rows and the cost row, works
// out the distance and match flag of every completed window and compares
// them with the results that the block hands out.
// ----------------------------------------------------------------------------
module dtw_gesture_match_check import dgm_pkg::*; #(
  parameter int WINDOW = 14,
  parameter int AXES   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_op,
  input  logic [3:0]            in_ref_index,
  input  logic signed [SW-1:0]  in_sample_x,
  input  logic signed [SW-1:0]  in_sample_y,
  input  logic signed [SW-1:0]  in_sample_z,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COST_W-1:0]     out_distance,
  input  logic                  out_is_match,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COST_W-1:0]     cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [COST_W-1:0] distance;
    logic              is_match;
  } window_score_t;

  window_score_t        window_scores[$];
  logic signed [SW-1:0] gesture_rows[WINDOW][3];
  logic [COST_W-1:0]    cost_cells[WINDOW];
  logic [CNT_W-1:0]     samples_taken = '0;
  logic [COST_W-1:0]    threshold     = THRESHOLD_RST;
  logic [CNT_W-1:0]     window_raw    = WINDOW_LEN_RST;

  function automatic logic [COST_W-1:0] add_sat(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  endfunction

  // one candidate sample: sweep the cost row, queue a score when the window closes
  task automatic sweep_sample(input logic signed [SW-1:0] sx, input logic signed [SW-1:0] sy,
                              input logic signed [SW-1:0] sz);
    logic signed [SW-1:0] axis[3];
    int                   len;
    logic                 first_row;
    logic [COST_W-1:0]    diag_cost, left_cost, up_cost, best, local_cost;
    longint               diff;
    window_score_t        score;
    axis[0] = sx;
    axis[1] = sy;
    axis[2] = sz;
    len = window_raw;
    if (len == 0) len = 1;
    if (len > WINDOW) len = WINDOW;
    first_row = (samples_taken == 0);
    diag_cost = '0;
    left_cost = '0;
    for (int j = 0; j < len; j++) begin
      local_cost = '0;
      for (int k = 0; k < AXES && k < 3; k++) begin
        diff = longint'(axis[k]) - longint'(gesture_rows[j][k]);
        local_cost = local_cost + COST_W'(diff * diff);
      end
      up_cost = cost_cells[j];
      if (first_row) best = (j == 0) ? '0 : left_cost;
      else if (j == 0) best = up_cost;
      else begin
        best = (left_cost < up_cost) ? left_cost : up_cost;
        if (diag_cost < best) best = diag_cost;
      end
      diag_cost = up_cost;
      left_cost = add_sat(local_cost, best);
      cost_cells[j] = left_cost;
    end
    samples_taken = samples_taken + 1'b1;
    if (samples_taken >= len || samples_taken == 0) begin
      samples_taken  = '0;
      score.distance = cost_cells[len-1];
      score.is_match = (score.distance < threshold);
      window_scores.push_back(score);
    end
  endtask

  always @(posedge clk) begin
    window_score_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD:  threshold  = cfg_data;
          CFG_WINDOW_LEN: window_raw = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_op == OP_REF_WRITE) begin
          if (in_ref_index < WINDOW) begin
            gesture_rows[in_ref_index][0] = in_sample_x;
            gesture_rows[in_ref_index][1] = in_sample_y;
            gesture_rows[in_ref_index][2] = in_sample_z;
          end
        end else begin
          sweep_sample(in_sample_x, in_sample_y, in_sample_z);
        end
      end
      if (out_valid && !out_stall) begin
        if (window_scores.size() == 0) begin
          $error("unexpected result: distance %0d, is_match %0d", out_distance, out_is_match);
          fail_count++;
        end else begin
          want = window_scores.pop_front();
          if (out_distance !== want.distance) begin
            $error("distance mismatch: expected %0d, got %0d", want.distance, out_distance);
            fail_count++;
          end
          if (out_is_match !== want.is_match) begin
            $error("is_match mismatch: expected %0d, got %0d", want.is_match, out_is_match);
            fail_count++;
          end
        end
      end
      pending = window_scores.size();
    end
  end

endmodule

FILE: tb/sv/dtw_gesture_match_test.sv
// ----------------------------------------------------------------------------
// dtw_gesture_match_test
// Drives reference rows, candidate samples and register writes into the
// gesture matcher under varying idle and stall patterns, including one long
// hold on the result side, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module dtw_gesture_match_test;
  import dgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 14;
  localparam int SETTLE       = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 24;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = OP_REF_WRITE;
  logic [3:0]           in_ref_index = '0;
  logic signed [SW-1:0] in_sample_x = '0;
  logic signed [SW-1:0] in_sample_y = '0;
  logic signed [SW-1:0] in_sample_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COST_W-1:0]    out_distance;
  logic                 out_is_match;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COST_W-1:0]    cfg_data = '0;
  int                   fail_count;
  int                   pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_cnt  = 0;
  // stimulus-side position in the current window, so the length is never raised mid-window
  int cur_len   = WINDOW;
  int win_pos   = 0;

  always #4 clk = ~clk;

  dtw_gesture_match #(.WINDOW(WINDOW), .AXES(3)) i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_ref_index,
    .in_sample_x, .in_sample_y, .in_sample_z,
    .out_valid, .out_stall, .out_distance, .out_is_match,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  dtw_gesture_match_check #(.WINDOW(WINDOW), .AXES(3)) i_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_ref_index,
    .in_sample_x, .in_sample_y, .in_sample_z,
    .out_valid, .out_stall, .out_distance, .out_is_match,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // result side: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #4ms;
    $display("dtw_gesture_match_test: FAIL");
    $finish;
  end

  function automatic int eff_len(logic [CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > WINDOW) return WINDOW;
    return raw;
  endfunction

  function automatic logic signed [SW-1:0] pick_axis();
    int v;
    if ($urandom_range(99) < 15) v = int'($urandom_range(8191)) - 4096;
    else v = int'($urandom_range(600)) - 300;
    return v[SW-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic op, input logic [3:0] idx,
                              input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
                              input logic signed [SW-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_ref_index <= idx;
    in_sample_x  <= x;
    in_sample_y  <= y;
    in_sample_z  <= z;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op == OP_SAMPLE) begin
      win_pos++;
      if (win_pos >= cur_len) win_pos = 0;
    end
  endtask

  task automatic send_random();
    if ($urandom_range(99) < 15)
      send_request(OP_REF_WRITE, 4'($urandom_range(15)), pick_axis(), pick_axis(), pick_axis());
    else
      send_request(OP_SAMPLE, 4'($urandom_range(15)), pick_axis(), pick_axis(), pick_axis());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_LEN) cur_len = eff_len(data[CNT_W-1:0]);
  endtask

  // drain: every result back, then let any sample still in the sweep finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [COST_W-1:0] thr;
    logic [COST_W-1:0] len_word;
    int                n_items;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reference rows, extremes first; indexes 14 and 15 must be ignored
    send_request(OP_REF_WRITE, 4'd0, -13'sd4096, -13'sd4096, -13'sd4096);
    send_request(OP_REF_WRITE, 4'd1, 13'sd4095, 13'sd4095, 13'sd4095);
    send_request(OP_REF_WRITE, 4'd2, 13'sd0, 13'sd0, 13'sd0);
    for (int r = 3; r < WINDOW; r++)
      send_request(OP_REF_WRITE, 4'(r), pick_axis(), pick_axis(), pick_axis());
    send_request(OP_REF_WRITE, 4'd14, 13'sd4095, -13'sd4096, 13'sd4095);
    send_request(OP_REF_WRITE, 4'd15, -13'sd4096, 13'sd4095, -13'sd4096);

    // zero threshold, zero length (one-sample windows)
    wait_idle();
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_WINDOW_LEN, '0);
    send_request(OP_SAMPLE, 4'd0, 13'sd4095, 13'sd4095, 13'sd4095);
    send_request(OP_SAMPLE, 4'd15, -13'sd4096, -13'sd4096, -13'sd4096);

    // full threshold, two-sample windows, then shorten mid-window
    wait_idle();
    write_reg(CFG_THRESHOLD, COST_MAX);
    write_reg(CFG_WINDOW_LEN, COST_W'(2));
    send_request(OP_SAMPLE, 4'd0, 13'sd0, 13'sd0, 13'sd0);
    send_request(OP_SAMPLE, 4'd0, 13'sd4095, -13'sd4096, 13'sd0);
    send_request(OP_SAMPLE, 4'd0, -13'sd1, 13'sd1, -13'sd4096);
    wait_idle();
    write_reg(CFG_WINDOW_LEN, COST_W'(1));
    send_request(OP_SAMPLE, 4'd0, pick_axis(), pick_axis(), pick_axis());

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      case ($urandom_range(5))
        0: thr = '0;
        1: thr = COST_MAX;
        2: thr = COST_W'({$urandom, $urandom});
        default: thr = COST_W'($urandom_range(8_000_000));
      endcase
      len_word = COST_W'({$urandom, $urandom});
      if (phase == 0) len_word[CNT_W-1:0] = 4'd15;
      else if (phase == 1) len_word[CNT_W-1:0] = 4'd1;
      else if (phase == 3) len_word[CNT_W-1:0] = 4'd2;
      // only shorten a window that is already open
      if (win_pos != 0 && eff_len(len_word[CNT_W-1:0]) > cur_len)
        len_word[CNT_W-1:0] = 4'($urandom_range(cur_len));
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_WINDOW_LEN, len_word);
      if (phase == 3) hold_req = 1'b1;
      n_items = $urandom_range(40, 60);
      repeat (n_items) send_random();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("dtw_gesture_match_test: PASS");
    end else begin
      $display("dtw_gesture_match_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/dgm_pkg.sv
hdl/dgm_local_cost.sv
hdl/dgm_cost_row.sv
hdl/dtw_gesture_match.sv
hdl/dgm_checker.sv
tb/sv/dtw_gesture_match_check.sv
tb/sv/dtw_gesture_match_test.sv
